[rtl/cdq_pkg.sv]
// Package for the circular deque unit: item structs, mode codes and sizing constants.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W = 5;
    localparam int VAL_W = 32;

    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'((DEPTH > 31) ? 31 : DEPTH);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'((16 > DEPTH) ? DEPTH : 16);
    localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(1);

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_REAR   = 3'd3;
    localparam logic [2:0] MODE_QUERY      = 3'd4;

    localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] rear_value;
        logic                    is_empty;
        logic                    is_full;
    } out_item_t;

    typedef struct packed {
        logic apply;
        logic cfg_write;
        logic read_en;
        logic load_out;
    } cdq_cmd_t;

endpackage

[rtl/cdq_ctrl.sv]
// Controller state machine of the circular deque unit.
// Sequences apply, slot read and result load; depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    output cdq_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.cfg_write = cfg_valid;
                cmd.apply     = in_valid && !cfg_valid;
                if (in_valid && !cfg_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/cdq_datapath.sv]
// Datapath of the circular deque unit: slot memory, ring pointers, capacity and result register.
// Driven by commands from cdq_ctrl; depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_datapath
    import cdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cdq_cmd_t         cmd,
    input  in_item_t         in_data,
    input  logic [CAP_W-1:0] cfg_data,
    output out_item_t        out_data
);

    logic [VAL_W-1:0] slots [DEPTH];

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic             empty_reg;
    logic             empty_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             ok_reg;
    logic             ok_next;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             full;
    logic [VAL_W-1:0] front_q_reg;
    logic [VAL_W-1:0] rear_q_reg;
    out_item_t        out_reg;

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i,
                                                  input logic [CAP_W-1:0] cap);
        logic [IDX_W-1:0] r;
        if (i == '0)
        begin
            r = IDX_W'(cap - CAP_MIN);
        end
        else
        begin
            r = i - IDX_W'(1);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        logic [IDX_W-1:0] r;
        n = CAP_W'(i) + CAP_MIN;
        if (n >= cap)
        begin
            r = '0;
        end
        else
        begin
            r = IDX_W'(n);
        end
        return r;
    endfunction

    assign full = !empty_reg && (head_reg == tail_reg);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        cap_next   = cap_reg;
        ok_next    = ok_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        if (cmd.cfg_write)
        begin
            if (cfg_data == '0)
            begin
                cap_next = CAP_MIN;
            end
            else if (cfg_data > CAP_MAX)
            begin
                cap_next = CAP_MAX;
            end
            else
            begin
                cap_next = cfg_data;
            end
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
        end
        else if (cmd.apply)
        begin
            ok_next = 1'b0;
            unique case (in_data.mode)
                MODE_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        head_next  = wrap_dec(head_reg, cap_reg);
                        wr_en      = 1'b1;
                        wr_addr    = head_next;
                        empty_next = 1'b0;
                        ok_next    = 1'b1;
                    end
                end
                MODE_PUSH_REAR:
                begin
                    if (!full)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        tail_next  = wrap_inc(tail_reg, cap_reg);
                        empty_next = 1'b0;
                        ok_next    = 1'b1;
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (!empty_reg)
                    begin
                        head_next  = wrap_inc(head_reg, cap_reg);
                        empty_next = (head_next == tail_reg);
                        ok_next    = 1'b1;
                    end
                end
                MODE_POP_REAR:
                begin
                    if (!empty_reg)
                    begin
                        tail_next  = wrap_dec(tail_reg, cap_reg);
                        empty_next = (head_reg == tail_next);
                        ok_next    = 1'b1;
                    end
                end
                MODE_QUERY:
                begin
                    ok_next = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        if (wr_en)
        begin
            slots[wr_addr] <= in_data.value;
        end
        if (cmd.read_en)
        begin
            front_q_reg <= slots[head_reg];
            rear_q_reg  <= slots[wrap_dec(tail_reg, cap_reg)];
        end
        if (cmd.load_out)
        begin
            out_reg.ok          <= ok_reg;
            out_reg.front_value <= empty_reg ? EMPTY_VALUE : front_q_reg;
            out_reg.rear_value  <= empty_reg ? EMPTY_VALUE : rear_q_reg;
            out_reg.is_empty    <= empty_reg;
            out_reg.is_full     <= full;
        end
    end

    assign out_data = out_reg;

endmodule

[rtl/circular_deque_unit.sv]
// Top level of the circular deque unit: joins the controller and the datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data   (in_item_t: mode, value)
// out       output     out_valid / out_ready  out_data  (out_item_t: ok, front, rear, flags)
// cfg       input      cfg_valid / cfg_ready  cfg_data  (capacity, 5 bits)
//
// Each transaction holds the block through its steps: the accepting cycle applies the operation,
// the read step reads the front and rear slots, and the load step loads the result and raises
// out_valid; the block takes no new transaction before the current one has been loaded.
// A new transaction is taken once the result is loaded, while that result still waits.
// A stalled output holds the block in its load step, and a capacity write blocks the input.
// Reset empties the deque and sets the capacity to 16; a capacity write empties it too.
`timescale 1ns / 1ps

module circular_deque_unit
    import cdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    cdq_cmd_t cmd;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    cdq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule

[rtl/cdq_checker.sv]
// Port-level checker for the circular deque unit, bound to the top level.
// Depends on cdq_pkg and circular_deque_unit.
`timescale 1ns / 1ps

module cdq_checker
    import cdq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input out_item_t        out_data,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Stalled result changed before its transaction.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input taken while a transaction is still in work.");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !in_ready)
        else $error("Input offered as ready during a capacity write.");

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_empty |->
            (out_data.front_value == EMPTY_VALUE) && (out_data.rear_value == EMPTY_VALUE))
        else $error("Empty deque reported values other than minus one.");

    a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.is_empty && out_data.is_full))
        else $error("Deque reported both empty and full.");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
